// File: design/metronome_beat_phase_timer_defines.svh
// assertion macros for the metronome beat phase timer
`ifndef METRONOME_BEAT_PHASE_TIMER_DEFINES_SVH
`define METRONOME_BEAT_PHASE_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
`define MBPT_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);
`define MBPT_ASSERT_NXT(lbl, c, r, pre, post, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) pre |=> post) else $error(msg);
`else
`define MBPT_ASSERT(lbl, c, r, prop, msg)
`define MBPT_ASSERT_NXT(lbl, c, r, pre, post, msg)
`endif

`endif

// File: design/mbpt_pkg.sv
// types, constants and helpers shared by the metronome beat phase timer
package mbpt_pkg;

  localparam int TEMPO_W = 11;
  localparam int GAP_W   = 16;
  localparam int PHASE_W = 16;
  localparam int TP_W    = 6;
  localparam int VAL_W   = 12;
  localparam int TSUM_W  = VAL_W + 1;

  localparam int BAR_LEDS    = 8;
  localparam int RING_LEDS   = 17;
  localparam int COLOR_SLOTS = 8;
  localparam int BAR_W       = 3;
  localparam int RING_W      = 5;
  localparam int COLOR_W     = 3;

  localparam int SLOT_MAX = (BAR_LEDS > RING_LEDS) ?
                            ((BAR_LEDS > COLOR_SLOTS) ? BAR_LEDS : COLOR_SLOTS) :
                            ((RING_LEDS > COLOR_SLOTS) ? RING_LEDS : COLOR_SLOTS);
  localparam int DIV_W = PHASE_W + $clog2(SLOT_MAX + 1);
  localparam int CNT_W = $clog2(DIV_W);

  localparam int TEMPO_MIN   = 1;
  localparam int TEMPO_MAX   = 1200;
  localparam int TEMPO_RST   = 60;
  localparam int MS_PER_MIN  = 60000;
  localparam int GAP_RST     = MS_PER_MIN / TEMPO_RST;
  localparam int TP_RST      = 16;
  localparam int WINDOW_DIV  = 25;
  localparam int WIN_W       = PHASE_W + $clog2(WINDOW_DIV);

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADJUST = 2'd1,
    ACT_SET    = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_GAP_LOAD,
    ST_GAP_RUN,
    ST_GAP_SAVE,
    ST_IDX_LOAD,
    ST_IDX_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo_bpm;
    logic [GAP_W-1:0]   beat_gap_ms;
    logic [PHASE_W-1:0] phase_ms;
    logic               beat_window;
    logic [BAR_W-1:0]   bar_led_index;
    logic [RING_W-1:0]  ring_led_index;
    logic [COLOR_W-1:0] color_index;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic wrap_step;
    logic gap_sel;
    logic div_load;
    logic div_step;
    logic gap_save;
    logic out_load;
  } ctrl_t;

  function automatic logic [TEMPO_W-1:0] clamp_tempo(input logic signed [TSUM_W-1:0] t);
    logic [TEMPO_W-1:0] res;
    if (t < $signed(TSUM_W'(TEMPO_MIN))) begin
      res = TEMPO_W'(TEMPO_MIN);
    end else if (t > $signed(TSUM_W'(TEMPO_MAX))) begin
      res = TEMPO_W'(TEMPO_MAX);
    end else begin
      res = t[TEMPO_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: design/mbpt_div_lane.sv
// bit-serial restoring divider lane, one quotient bit per step
module mbpt_div_lane (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic [mbpt_pkg::DIV_W-1:0] dividend,
  input  logic [mbpt_pkg::GAP_W-1:0] divisor,
  output logic [mbpt_pkg::DIV_W-1:0] quotient
);

  logic [mbpt_pkg::GAP_W-1:0] rem_r, rem_nxt;
  logic [mbpt_pkg::GAP_W-1:0] dvs_r, dvs_nxt;
  logic [mbpt_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [mbpt_pkg::GAP_W:0]   trial;
  logic [mbpt_pkg::GAP_W+1:0] diff;
  logic                       fits;

  always_comb begin
    trial = {rem_r, quo_r[mbpt_pkg::DIV_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_r};
    fits  = !diff[mbpt_pkg::GAP_W+1];
  end

  always_comb begin
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    quo_nxt = quo_r;
    if (load) begin
      rem_nxt = '0;
      dvs_nxt = divisor;
      quo_nxt = dividend;
    end else if (step) begin
      // remainder stays below the divisor, so both picks fit
      rem_nxt = fits ? diff[mbpt_pkg::GAP_W-1:0] : trial[mbpt_pkg::GAP_W-1:0];
      quo_nxt = {quo_r[mbpt_pkg::DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

// File: design/mbpt_ctrl.sv
// sequencer for item intake, phase wrap and the serial divide runs
module mbpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_action,
  input  logic            wrap_ge,
  input  logic            out_valid,
  input  logic            out_ready,
  output logic            in_ready,
  output mbpt_pkg::ctrl_t ctrl
);

  mbpt_pkg::state_t           state_r, state_nxt;
  logic [mbpt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       cnt_last;
  logic                       out_free;

  assign cnt_last = (cnt_r == mbpt_pkg::CNT_W'(mbpt_pkg::DIV_W - 1));
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (mbpt_pkg::action_t'(in_action))
            mbpt_pkg::ACT_TICK:   state_nxt = mbpt_pkg::ST_WRAP;
            mbpt_pkg::ACT_ADJUST: state_nxt = mbpt_pkg::ST_GAP_LOAD;
            mbpt_pkg::ACT_SET:    state_nxt = mbpt_pkg::ST_GAP_LOAD;
            default:              state_nxt = mbpt_pkg::ST_IDX_LOAD;
          endcase
        end
      end
      mbpt_pkg::ST_WRAP: begin
        if (!wrap_ge) state_nxt = mbpt_pkg::ST_IDX_LOAD;
      end
      mbpt_pkg::ST_GAP_LOAD: state_nxt = mbpt_pkg::ST_GAP_RUN;
      mbpt_pkg::ST_GAP_RUN: begin
        if (cnt_last) state_nxt = mbpt_pkg::ST_GAP_SAVE;
      end
      mbpt_pkg::ST_GAP_SAVE: state_nxt = mbpt_pkg::ST_IDX_LOAD;
      mbpt_pkg::ST_IDX_LOAD: state_nxt = mbpt_pkg::ST_IDX_RUN;
      mbpt_pkg::ST_IDX_RUN: begin
        if (cnt_last) state_nxt = mbpt_pkg::ST_DONE;
      end
      mbpt_pkg::ST_DONE: begin
        if (out_free) state_nxt = mbpt_pkg::ST_IDLE;
      end
      default: state_nxt = mbpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    case (state_r)
      mbpt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctrl.accept = in_valid;
      end
      mbpt_pkg::ST_WRAP:     ctrl.wrap_step = 1'b1;
      mbpt_pkg::ST_GAP_LOAD: begin
        ctrl.gap_sel  = 1'b1;
        ctrl.div_load = 1'b1;
      end
      mbpt_pkg::ST_GAP_RUN:  ctrl.div_step = 1'b1;
      mbpt_pkg::ST_GAP_SAVE: ctrl.gap_save = 1'b1;
      mbpt_pkg::ST_IDX_LOAD: ctrl.div_load = 1'b1;
      mbpt_pkg::ST_IDX_RUN:  ctrl.div_step = 1'b1;
      mbpt_pkg::ST_DONE:     ctrl.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.div_load) begin
      cnt_nxt = '0;
    end else if (ctrl.div_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbpt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: design/metronome_beat_phase_timer.sv
// Metronome beat phase timer: tempo, beat period and phase within the beat.
// Input channel (in_valid/in_ready/in_beat) takes one beat per item: a tick
// advances the phase by the tick period and wraps it at the beat period;
// adjust and set change the tempo (held to 1..1200), recompute the period
// as 60000 / tempo and clear the phase. Every item yields one result beat on
// out_valid/out_ready with the tempo, period, phase, beat window flag and
// the bar, ring and color indices taken from the updated state.
// cfg_valid/cfg_ready/cfg_data writes the tick period; write it while idle.
// After accept, an unused action code goes straight to the index divide,
// a tick first runs one to three wrap steps, a tempo change the period divide.
// The indices come from three 21-step bit-serial divider lanes run side by
// side; a tempo change first runs the period divide in the bar lane. One
// item occupies the block until its result enters the output register, and
// the next item is taken right after.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls; only the next result waits until that one is taken.
// Reset (rst_n low, synchronous) sets tempo 60, period 1000, phase 0 and
// tick period 16, and drops out_valid.
`include "metronome_beat_phase_timer_defines.svh"

module metronome_beat_phase_timer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mbpt_pkg::in_beat_t        in_beat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mbpt_pkg::out_beat_t       out_beat,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mbpt_pkg::TP_W-1:0] cfg_data
);

  mbpt_pkg::ctrl_t ctrl;

  logic [mbpt_pkg::TP_W-1:0]    tp_r, tp_nxt;
  logic [mbpt_pkg::TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [mbpt_pkg::GAP_W-1:0]   gap_r, gap_nxt;
  logic [mbpt_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [mbpt_pkg::PHASE_W:0]   sum_r, sum_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mbpt_pkg::out_beat_t          out_beat_r, out_beat_nxt;

  logic                                wrap_ge;
  logic signed [mbpt_pkg::TSUM_W-1:0]  tsum;
  logic [mbpt_pkg::DIV_W-1:0]          phase_ext;
  logic [mbpt_pkg::DIV_W-1:0]          bar_div, ring_div, color_div;
  logic [mbpt_pkg::GAP_W-1:0]          bar_dvs;
  logic [mbpt_pkg::DIV_W-1:0]          bar_q, ring_q, color_q;
  logic [mbpt_pkg::WIN_W-1:0]          win_prod;
  logic                                win_flag;
  logic                                tempo_ok;
  logic                                out_free;
  logic                                in_fire;

  mbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_beat.action),
    .wrap_ge   (wrap_ge),
    .out_valid (out_valid_r),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  assign phase_ext = {{(mbpt_pkg::DIV_W - mbpt_pkg::PHASE_W){1'b0}}, phase_r};
  // bar lane doubles as the period divider on a tempo change
  assign bar_div   = ctrl.gap_sel ? mbpt_pkg::DIV_W'(mbpt_pkg::MS_PER_MIN)
                                  : mbpt_pkg::DIV_W'(mbpt_pkg::BAR_LEDS) * phase_ext;
  assign bar_dvs   = ctrl.gap_sel ? {{(mbpt_pkg::GAP_W - mbpt_pkg::TEMPO_W){1'b0}}, tempo_r}
                                  : gap_r;
  assign ring_div  = mbpt_pkg::DIV_W'(mbpt_pkg::RING_LEDS) * phase_ext;
  assign color_div = mbpt_pkg::DIV_W'(mbpt_pkg::COLOR_SLOTS) * phase_ext;

  mbpt_div_lane u_bar_lane (
    .clk      (clk),
    .load     (ctrl.div_load),
    .step     (ctrl.div_step),
    .dividend (bar_div),
    .divisor  (bar_dvs),
    .quotient (bar_q)
  );

  mbpt_div_lane u_ring_lane (
    .clk      (clk),
    .load     (ctrl.div_load),
    .step     (ctrl.div_step),
    .dividend (ring_div),
    .divisor  (gap_r),
    .quotient (ring_q)
  );

  mbpt_div_lane u_color_lane (
    .clk      (clk),
    .load     (ctrl.div_load),
    .step     (ctrl.div_step),
    .dividend (color_div),
    .divisor  (gap_r),
    .quotient (color_q)
  );

  assign wrap_ge   = (sum_r >= {1'b0, gap_r});
  assign cfg_ready = in_ready;

  assign win_prod = mbpt_pkg::WIN_W'(mbpt_pkg::WINDOW_DIV) *
                    {{(mbpt_pkg::WIN_W - mbpt_pkg::PHASE_W){1'b0}}, phase_r};
  assign win_flag = (win_prod < {{(mbpt_pkg::WIN_W - mbpt_pkg::GAP_W){1'b0}}, gap_r});

  always_comb begin
    if (mbpt_pkg::action_t'(in_beat.action) == mbpt_pkg::ACT_ADJUST) begin
      tsum = $signed({2'b00, tempo_r}) + $signed({in_beat.value[mbpt_pkg::VAL_W-1],
                                                  in_beat.value});
    end else begin
      tsum = $signed({in_beat.value[mbpt_pkg::VAL_W-1], in_beat.value});
    end
  end

  always_comb begin
    tp_nxt        = tp_r;
    tempo_nxt     = tempo_r;
    gap_nxt       = gap_r;
    phase_nxt     = phase_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;

    if (cfg_valid && cfg_ready) tp_nxt = cfg_data;

    if (ctrl.accept) begin
      case (mbpt_pkg::action_t'(in_beat.action))
        mbpt_pkg::ACT_TICK: begin
          sum_nxt = {1'b0, phase_r} + {{(mbpt_pkg::PHASE_W + 1 - mbpt_pkg::TP_W){1'b0}}, tp_r};
        end
        mbpt_pkg::ACT_ADJUST, mbpt_pkg::ACT_SET: begin
          tempo_nxt = mbpt_pkg::clamp_tempo(tsum);
          phase_nxt = '0;
        end
        default: ;
      endcase
    end

    // at most a couple of subtractions, since the phase stays below the period
    if (ctrl.wrap_step) begin
      if (wrap_ge) begin
        sum_nxt = sum_r - {1'b0, gap_r};
      end else begin
        phase_nxt = sum_r[mbpt_pkg::PHASE_W-1:0];
      end
    end

    if (ctrl.gap_save) gap_nxt = bar_q[mbpt_pkg::GAP_W-1:0];

    if (ctrl.out_load) begin
      out_valid_nxt               = 1'b1;
      out_beat_nxt.tempo_bpm      = tempo_r;
      out_beat_nxt.beat_gap_ms    = gap_r;
      out_beat_nxt.phase_ms       = phase_r;
      out_beat_nxt.beat_window    = win_flag;
      out_beat_nxt.bar_led_index  = bar_q[mbpt_pkg::BAR_W-1:0];
      out_beat_nxt.ring_led_index = ring_q[mbpt_pkg::RING_W-1:0];
      out_beat_nxt.color_index    = color_q[mbpt_pkg::COLOR_W-1:0];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r        <= mbpt_pkg::TP_W'(mbpt_pkg::TP_RST);
      tempo_r     <= mbpt_pkg::TEMPO_W'(mbpt_pkg::TEMPO_RST);
      gap_r       <= mbpt_pkg::GAP_W'(mbpt_pkg::GAP_RST);
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tp_r        <= tp_nxt;
      tempo_r     <= tempo_nxt;
      gap_r       <= gap_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign tempo_ok = (tempo_r >= mbpt_pkg::TEMPO_W'(mbpt_pkg::TEMPO_MIN)) &&
                    (tempo_r <= mbpt_pkg::TEMPO_W'(mbpt_pkg::TEMPO_MAX));
  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  `MBPT_ASSERT(a_phase_below_gap, clk, rst_n, in_ready |-> (phase_r < gap_r), "phase past period")
  `MBPT_ASSERT(a_tempo_range, clk, rst_n, tempo_ok, "tempo out of range")
  `MBPT_ASSERT(a_no_overwrite, clk, rst_n, ctrl.out_load |-> out_free, "result overwritten")
  `MBPT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready, "beat taken while busy")

endmodule

// File: test/tb.sv
// self-checking testbench for the metronome beat phase timer
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbpt_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_beat_t            in_beat = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_beat_t           out_beat;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TP_W-1:0]     cfg_data = '0;

  // model of the timer state
  logic [TEMPO_W-1:0]  cur_tempo;
  logic [GAP_W-1:0]    cur_gap;
  logic [PHASE_W-1:0]  cur_phase;
  logic [TP_W-1:0]     tick_ms;

  out_beat_t           expected_beats[$];
  int                  error_count = 0;

  // sender and receiver pacing
  int                  burst_left = 0;
  int                  gap_max = 3;
  bit                  rx_stalls = 1'b1;
  int                  hold_req = 0;
  int                  hold_left = 0;
  logic [7:0]          stall_pat = 8'b1011_0110;
  int                  idle_cycles = 0;

  metronome_beat_phase_timer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 100) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  function automatic void retune(input int bpm);
    if (bpm < TEMPO_MIN) begin
      bpm = TEMPO_MIN;
    end else if (bpm > TEMPO_MAX) begin
      bpm = TEMPO_MAX;
    end
    cur_tempo = TEMPO_W'(bpm);
    cur_gap   = GAP_W'(MS_PER_MIN / bpm);
    cur_phase = '0;
  endfunction

  // applies one beat to the model and returns the result it should produce
  function automatic out_beat_t advance_metronome(input in_beat_t b);
    out_beat_t r;
    int        delta;
    int        ph;
    int        gap;
    delta = $signed(b.value);
    case (action_t'(b.action))
      ACT_TICK: begin
        cur_phase = PHASE_W'((int'(cur_phase) + int'(tick_ms)) % int'(cur_gap));
      end
      ACT_ADJUST: begin
        retune(int'(cur_tempo) + delta);
      end
      ACT_SET: begin
        retune(delta);
      end
      default: begin
      end
    endcase
    ph  = cur_phase;
    gap = cur_gap;
    r.tempo_bpm      = cur_tempo;
    r.beat_gap_ms    = cur_gap;
    r.phase_ms       = cur_phase;
    r.beat_window    = (WINDOW_DIV * ph) < gap;
    r.bar_led_index  = BAR_W'((BAR_LEDS * ph) / gap);
    r.ring_led_index = RING_W'((RING_LEDS * ph) / gap);
    r.color_index    = COLOR_W'((COLOR_SLOTS * ph) / gap);
    return r;
  endfunction

  // mostly ticks so the phase sweeps whole beats, tempo changes now and then
  function automatic in_beat_t pick_random_beat();
    in_beat_t b;
    int       r;
    int       v;
    r = $urandom_range(0, 99);
    v = $urandom_range(0, 4095);
    if (r < 78) begin
      b.action = ACT_TICK;
    end else if (r < 86) begin
      b.action = ACT_SET;
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom_range(0, 4095);
      end else if ($urandom_range(0, 2) == 0) begin
        v = $urandom_range(1, 60);
      end else begin
        v = $urandom_range(61, TEMPO_MAX);
      end
    end else if (r < 95) begin
      b.action = ACT_ADJUST;
      if ($urandom_range(0, 3) != 0) begin
        v = int'($urandom_range(0, 80)) - 40;
      end
    end else begin
      b.action = ACT_NOP;
    end
    b.value = VAL_W'(v);
    return b;
  endfunction

  task automatic send_beat(input logic [1:0] act, input int val);
    in_beat_t b;
    int       gap;
    b.action = act;
    b.value  = VAL_W'(val);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
      end
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_beat  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_beats.push_back(advance_metronome(b));
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_tick_period(input int ms);
    wait_results_done();
    @(negedge clk);
    cfg_data  <= TP_W'(ms);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tick_ms = TP_W'(ms);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_beat(ACT_NOP, 0);
    send_beat(ACT_TICK, 0);
  endtask

  task automatic test_tempo_limits();
    send_beat(ACT_SET, 1);
    send_beat(ACT_TICK, 0);
    send_beat(ACT_SET, TEMPO_MAX);
    // 50 ms beat wraps on the fourth tick
    repeat (4) send_beat(ACT_TICK, 0);
    send_beat(ACT_SET, -2048);
    send_beat(ACT_SET, 2047);
    send_beat(ACT_SET, 0);
    send_beat(ACT_ADJUST, 2047);
    send_beat(ACT_ADJUST, -2048);
    send_beat(ACT_ADJUST, 0);
    send_beat(ACT_SET, TEMPO_MAX + 1);
    send_beat(ACT_ADJUST, -1);
    send_beat(ACT_NOP, -1);
  endtask

  task automatic test_tick_period_limits();
    write_tick_period(0);
    send_beat(ACT_TICK, 0);
    write_tick_period(63);
    send_beat(ACT_SET, TEMPO_MAX);
    send_beat(ACT_TICK, 0);
    send_beat(ACT_TICK, 0);
    write_tick_period(49);
    send_beat(ACT_TICK, 0);
    write_tick_period(TP_RST);
  endtask

  task automatic test_random_traffic();
    int       periods[5];
    int       counts[5];
    int       gaps[5];
    bit       stalls[5];
    in_beat_t b;
    periods = '{49, 1, 63, 0, 24};
    counts  = '{330, 330, 330, 60, 330};
    gaps    = '{5, 0, 8, 3, 4};
    stalls  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    periods[4] = $urandom_range(2, 48);
    for (int p = 0; p < 5; p++) begin
      write_tick_period(periods[p]);
      @(posedge clk);
      gap_max   = gaps[p];
      rx_stalls = stalls[p];
      repeat (counts[p]) begin
        b = pick_random_beat();
        send_beat(b.action, b.value);
      end
    end
  endtask

  task automatic test_output_backpressure();
    in_beat_t b;
    wait_results_done();
    @(posedge clk);
    gap_max   = 0;
    rx_stalls = 1'b1;
    hold_req  = HOLD_CYCLES;
    repeat (24) begin
      b = pick_random_beat();
      send_beat(b.action, b.value);
    end
  endtask

  initial begin
    tick_ms = TP_W'(TP_RST);
    retune(TEMPO_RST);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_tempo_limits();
    test_tick_period_limits();
    test_random_traffic();
    test_output_backpressure();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_beats.size()));
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: long hold-off on request, otherwise a rotating stall pattern if stalls are on, else always ready
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stalls) begin
      out_ready <= stall_pat[0];
      if ($urandom_range(0, 15) == 0) begin
        stall_pat = 8'($urandom);
      end else begin
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_error("result beat with nothing pending");
      end else begin
        want = expected_beats.pop_front();
        if (out_beat.tempo_bpm !== want.tempo_bpm)
          report_error($sformatf("tempo_bpm got %0d want %0d",
                                 out_beat.tempo_bpm, want.tempo_bpm));
        if (out_beat.beat_gap_ms !== want.beat_gap_ms)
          report_error($sformatf("beat_gap_ms got %0d want %0d",
                                 out_beat.beat_gap_ms, want.beat_gap_ms));
        if (out_beat.phase_ms !== want.phase_ms)
          report_error($sformatf("phase_ms got %0d want %0d",
                                 out_beat.phase_ms, want.phase_ms));
        if (out_beat.beat_window !== want.beat_window)
          report_error($sformatf("beat_window got %0d want %0d",
                                 out_beat.beat_window, want.beat_window));
        if (out_beat.bar_led_index !== want.bar_led_index)
          report_error($sformatf("bar_led_index got %0d want %0d",
                                 out_beat.bar_led_index, want.bar_led_index));
        if (out_beat.ring_led_index !== want.ring_led_index)
          report_error($sformatf("ring_led_index got %0d want %0d",
                                 out_beat.ring_led_index, want.ring_led_index));
        if (out_beat.color_index !== want.color_index)
          report_error($sformatf("color_index got %0d want %0d",
                                 out_beat.color_index, want.color_index));
      end
    end
  end

  // watchdog on cycles in which no channel moves a beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
